// ----- rtl/core/deq_pkg.sv -----
// Shared constants, codes, types and ring-pointer helper for the double-ended queue.
package deq_pkg;

    // Ring store geometry.
    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;

    // Field widths.
    localparam int KIND_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LIST       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Command from the controller to the entry memory.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_cmd_t;

    // Slot that lies off entries past base, wrapped around the ring.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/core/deq_req_if.sv -----
// Request channel interface: operation kind and value to push.
interface deq_req_if;
    logic                           valid;
    logic                           ready;
    logic [deq_pkg::KIND_W-1:0]     kind;
    logic signed [deq_pkg::DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/core/deq_rsp_if.sv -----
// Result channel interface: status, popped or listed value and last mark.
interface deq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic                              has_value;
    logic signed [deq_pkg::DATA_W-1:0] value_res;
    logic                              last;

    modport source (output valid, output status, output has_value, output value_res,
                    output last, input ready);
    modport sink   (input valid, input status, input has_value, input value_res,
                    input last, output ready);
endinterface

// ----- rtl/core/deq_ram.sv -----
// Entry memory of the ring: one write port, one read port, registered read data.
module deq_ram (
    input  logic                      clk,
    input  deq_pkg::ram_cmd_t         cmd,
    output logic [deq_pkg::DATA_W-1:0] rdata
);
    import deq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rdata_reg <= mem[cmd.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/deq_ctrl.sv -----
// Queue sequencer: ring pointers, operation decode, listing walk and result register.
module deq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    deq_req_if.sink                    req,
    deq_rsp_if.source                  rsp,
    output deq_pkg::ram_cmd_t          cmd,
    input  logic [deq_pkg::DATA_W-1:0] rdata
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_LIST = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   list_ptr_reg, list_ptr_next;
    logic [CNT_W-1:0]   list_left_reg, list_left_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_hv_reg;
    logic [DATA_W-1:0]   out_val_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic [IDX_W-1:0]    front_dec;
    logic                out_load;
    logic [STATUS_W-1:0] ld_status;
    logic                ld_hv;
    logic [DATA_W-1:0]   ld_val;
    logic                ld_last;

    // Handshake and queue condition flags.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);

    // Next-state logic. Requests are taken one at a time, so a write and a
    // later read of the same slot never overlap inside the memory.
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        list_ptr_next  = list_ptr_reg;
        list_left_next = list_left_reg;
        cmd            = '0;
        out_load       = 1'b0;
        ld_status      = ST_OK;
        ld_hv          = 1'b0;
        ld_val         = '0;
        ld_last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                ld_status = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.we    = 1'b1;
                                cmd.wdata = req.value;
                                if (req.kind == KIND_PUSH_FRONT)
                                begin
                                    cmd.waddr  = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    cmd.waddr = wrap_add(front_reg, count_reg);
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_LIST:
                        begin
                            if (is_empty)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.re         = 1'b1;
                                cmd.raddr      = front_reg;
                                list_ptr_next  = wrap_add(front_reg, CNT_W'(1));
                                list_left_next = count_reg;
                                state_next     = S_LIST;
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.re = 1'b1;
                                if (req.kind == KIND_POP_FRONT)
                                begin
                                    cmd.raddr  = front_reg;
                                    front_next = wrap_add(front_reg, CNT_W'(1));
                                end
                                else
                                begin
                                    cmd.raddr = wrap_add(front_reg,
                                                         count_reg - CNT_W'(1));
                                end
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            out_load  = 1'b1;
                            ld_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // The result register was drained when the pop was taken.
                out_load   = 1'b1;
                ld_hv      = 1'b1;
                ld_val     = rdata;
                state_next = S_IDLE;
            end
            S_LIST:
            begin
                // Hand out one entry per free result slot, reading the next ahead.
                if (out_free)
                begin
                    out_load       = 1'b1;
                    ld_hv          = 1'b1;
                    ld_val         = rdata;
                    ld_last        = (list_left_reg == CNT_W'(1));
                    list_left_next = list_left_reg - CNT_W'(1);
                    if (list_left_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.re        = 1'b1;
                        cmd.raddr     = list_ptr_reg;
                        list_ptr_next = wrap_add(list_ptr_reg, CNT_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            list_ptr_reg  <= '0;
            list_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            list_ptr_reg  <= list_ptr_next;
            list_left_reg <= list_left_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_hv_reg     <= ld_hv;
            out_val_reg    <= ld_val;
            out_last_reg   <= ld_last;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.has_value = out_hv_reg;
    assign rsp.value_res = out_val_reg;
    assign rsp.last      = out_last_reg;

`ifndef NO_ASSERTIONS
    // The entry count never passes the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds ring size");

    // The memory is written only while decoding a fresh request.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.we |-> (state_reg == S_IDLE) && accept)
        else $error("memory write outside request decode");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

    // A listing walk always has entries left to hand out.
    a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (list_left_reg != '0))
        else $error("listing walk with nothing left");

    // A pop finishes in the cycle after its memory read.
    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("pop result not delivered");
`endif

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed 32-bit entries.
//
//   channel  dir   fields                               transfer
//   req      in    kind, value                          valid & ready
//   rsp      out   status, has_value, value_res, last   valid & ready
//
// Pushes, refused requests and invalid kinds load their result register straight from the decode.
// Pops first read the entry memory, then register the result.
// A listing hands out one stored entry per cycle while the result channel is free, after its first read.
// The registered read of the entry memory is why pops and listings wait for a read first.
// Reset clears the state, pointers, count and result valid flag only; the memory needs no clearing pass.
// A stalled result holds in its register and the next request waits for it.
module double_ended_queue (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    ram_cmd_t          cmd;
    logic [DATA_W-1:0] rdata;

    // Sequencer: pointers, decode, listing walk and result register.
    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .rdata (rdata)
    );

    // Ring entry memory.
    deq_ram u_ram (
        .clk   (clk),
        .cmd   (cmd),
        .rdata (rdata)
    );

endmodule
